>>> hw/rtl/rbcc_pkg.sv
package rbcc_pkg;

  localparam int NUM_BOXES     = 3;
  localparam int ARENA_WIDTH   = 16384;
  localparam int ARENA_HEIGHT  = 8192;
  localparam int CORDIC_STEPS  = 15;
  localparam int CORDIC_X0     = 19899;
  localparam int NUM_RECTS     = NUM_BOXES + 1;
  localparam int NUM_PAIRS     = NUM_RECTS * 16;

  // coordinate, difference and product widths
  localparam int TW = 18;
  localparam int CW = 20;
  localparam int DW = 21;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  // register indexes
  localparam logic [2:0] REG_OBST_EN  = 3'd0;
  localparam logic [2:0] REG_VEH_LEN  = 3'd1;
  localparam logic [2:0] REG_VEH_WID  = 3'd2;
  localparam logic [2:0] REG_BOX_WID  = 3'd3;
  localparam logic [2:0] REG_BOX_HGT  = 3'd4;
  localparam logic [2:0] REG_BOX0     = 3'd5;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
    logic                 flip;
    logic signed [15:0]   px;
    logic signed [15:0]   py;
  } cst_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef struct packed {
    pt_t a;
    pt_t b;
    pt_t c;
    pt_t d;
  } corners_t;

  function automatic logic signed [TW-1:0] atan_turn(int i);
    logic signed [TW-1:0] r;
    case (i)
      0:       r = 18'sd8192;
      1:       r = 18'sd4836;
      2:       r = 18'sd2555;
      3:       r = 18'sd1297;
      4:       r = 18'sd651;
      5:       r = 18'sd326;
      6:       r = 18'sd163;
      7:       r = 18'sd81;
      8:       r = 18'sd41;
      9:       r = 18'sd20;
      10:      r = 18'sd10;
      11:      r = 18'sd5;
      12:      r = 18'sd3;
      13:      r = 18'sd1;
      14:      r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic cst_t cordic_step(cst_t s, int i);
    cst_t r;
    logic signed [TW-1:0] xs;
    logic signed [TW-1:0] ys;
    xs = s.x >>> i;
    ys = s.y >>> i;
    r  = s;
    if (!s.z[TW-1]) begin
      r.x = s.x - ys;
      r.y = s.y + xs;
      r.z = s.z - atan_turn(i);
    end else begin
      r.x = s.x + ys;
      r.y = s.y - xs;
      r.z = s.z + atan_turn(i);
    end
    return r;
  endfunction

  // round(ext * trig / 2^16), floor after adding half
  function automatic logic signed [TW-1:0] half_term(logic [12:0] ext,
                                                     logic signed [TW-1:0] trig);
    logic signed [33:0] p;
    p = 34'($signed({1'b0, ext})) * 34'(trig) + 34'sd32768;
    return p[33:16];
  endfunction

endpackage

>>> hw/rtl/rbcc_front.sv
module rbcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [15:0]         heading,
  input  logic [12:0]         vehicle_length,
  input  logic [12:0]         vehicle_width,
  output logic                push,
  output rbcc_pkg::corners_t  corners,
  input  logic                q_full
);
  import rbcc_pkg::*;

  localparam int NV = CORDIC_STEPS + 3;

  logic [NV-1:0] v;
  logic          fe;
  cst_t          st [0:CORDIC_STEPS];
  cst_t          st0_next;
  logic [15:0]   h;
  logic          flip;

  logic signed [TW-1:0] hlc, hls, hwc, hws;
  logic signed [15:0]   mpx, mpy;
  logic signed [TW-1:0] c, s;

  assign fe       = !v[NV-1] || !q_full;
  assign in_ready = fe;
  assign push     = v[NV-1] && !q_full;

  always_comb begin
    flip = (heading >= 16'd16384) && (heading < 16'd49152);
    h    = flip ? (heading - 16'd32768) : heading;
    st0_next.x    = 18'(CORDIC_X0);
    st0_next.y    = '0;
    st0_next.z    = 18'($signed(h));
    st0_next.flip = flip;
    st0_next.px   = pos_x;
    st0_next.py   = pos_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (fe) begin
      v <= {v[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (fe) st[0] <= st0_next;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (fe) st[i+1] <= cordic_step(st[i], i);
    end
  end

  assign c = st[CORDIC_STEPS].flip ? -st[CORDIC_STEPS].x : st[CORDIC_STEPS].x;
  assign s = st[CORDIC_STEPS].flip ? -st[CORDIC_STEPS].y : st[CORDIC_STEPS].y;

  always_ff @(posedge clk) begin
    if (fe) begin
      hlc <= half_term(vehicle_length, c);
      hls <= half_term(vehicle_length, s);
      hwc <= half_term(vehicle_width, c);
      hws <= half_term(vehicle_width, s);
      mpx <= st[CORDIC_STEPS].px;
      mpy <= st[CORDIC_STEPS].py;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      corners.a.x <= CW'(mpx) + CW'(hlc) - CW'(hws);
      corners.a.y <= CW'(mpy) + CW'(hls) + CW'(hwc);
      corners.b.x <= CW'(mpx) + CW'(hlc) + CW'(hws);
      corners.b.y <= CW'(mpy) + CW'(hls) - CW'(hwc);
      corners.c.x <= CW'(mpx) - CW'(hlc) - CW'(hws);
      corners.c.y <= CW'(mpy) - CW'(hls) + CW'(hwc);
      corners.d.x <= CW'(mpx) - CW'(hlc) + CW'(hws);
      corners.d.y <= CW'(mpy) - CW'(hls) - CW'(hwc);
    end
  end

endmodule

>>> hw/rtl/rbcc_fifo.sv
module rbcc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rbcc_pkg::corners_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output rbcc_pkg::corners_t rdata
);
  import rbcc_pkg::*;

  corners_t   mem [0:3];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full      = (cnt == 3'd4);
  assign not_empty = (cnt != 3'd0);
  assign rdata     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
  end

endmodule

>>> hw/rtl/rbcc_back.sv
module rbcc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_not_empty,
  output logic                            pop,
  input  rbcc_pkg::corners_t              corners,
  input  logic                            obstacles_enabled,
  input  logic [12:0]                     box_width,
  input  logic [12:0]                     box_height,
  input  logic [rbcc_pkg::NUM_BOXES-1:0][31:0] box_corner,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            collided
);
  import rbcc_pkg::*;

  logic                 be;
  logic                 v1, v2;
  logic [NUM_PAIRS-1:0] hit;
  logic signed [CW-1:0] rx0 [0:NUM_RECTS-1];
  logic signed [CW-1:0] ry0 [0:NUM_RECTS-1];
  logic signed [CW-1:0] rx1 [0:NUM_RECTS-1];
  logic signed [CW-1:0] ry1 [0:NUM_RECTS-1];

  assign be  = !out_valid || out_ready;
  assign pop = q_not_empty && be;

  // rectangle bounds: boxes from config, arena last
  for (genvar r = 0; r < NUM_RECTS; r++) begin : g_rect
    if (r < NUM_BOXES) begin : g_box
      assign rx0[r] = CW'($signed(box_corner[r][31:16]));
      assign ry1[r] = CW'($signed(box_corner[r][15:0]));
      assign rx1[r] = CW'($signed(box_corner[r][31:16])) + CW'(box_width);
      assign ry0[r] = CW'($signed(box_corner[r][15:0])) - CW'(box_height);
    end else begin : g_arena
      assign rx0[r] = '0;
      assign ry0[r] = '0;
      assign rx1[r] = CW'(ARENA_WIDTH);
      assign ry1[r] = CW'(ARENA_HEIGHT);
    end
  end

  for (genvar r = 0; r < NUM_RECTS; r++) begin : g_r
    for (genvar e = 0; e < 4; e++) begin : g_e
      for (genvar k = 0; k < 4; k++) begin : g_k
        logic signed [CW-1:0] p1x, p1y, p2x, p2y;
        pt_t                  q1, q2;
        logic signed [DW-1:0] ax, ay, bx, by, cx, cy;
        logic signed [PW-1:0] m_aybx, m_axby, m_bycx, m_bxcy, m_axcy, m_aycx;
        logic signed [NW-1:0] den, na, nb;

        // rect edges: right, bottom, left, top
        assign p1x = (e == 2 || e == 1) ? rx0[r] : (e == 3 ? rx0[r] : rx1[r]);
        assign p1y = (e == 3) ? ry1[r] : ry0[r];
        assign p2x = (e == 2) ? rx0[r] : rx1[r];
        assign p2y = (e == 1) ? ry0[r] : ry1[r];
        // vehicle sides: a-b, a-c, c-d, b-d
        assign q1 = (k == 0 || k == 1) ? corners.a : (k == 2 ? corners.c : corners.b);
        assign q2 = (k == 0) ? corners.b : (k == 1 ? corners.c : corners.d);

        always_ff @(posedge clk) begin
          if (be) begin
            ax <= DW'(p2x) - DW'(p1x);
            ay <= DW'(p2y) - DW'(p1y);
            bx <= DW'(q1.x) - DW'(q2.x);
            by <= DW'(q1.y) - DW'(q2.y);
            cx <= DW'(p1x) - DW'(q1.x);
            cy <= DW'(p1y) - DW'(q1.y);
            m_aybx <= PW'(ay) * PW'(bx);
            m_axby <= PW'(ax) * PW'(by);
            m_bycx <= PW'(by) * PW'(cx);
            m_bxcy <= PW'(bx) * PW'(cy);
            m_axcy <= PW'(ax) * PW'(cy);
            m_aycx <= PW'(ay) * PW'(cx);
          end
        end

        assign den = NW'(m_aybx) - NW'(m_axby);
        assign na  = NW'(m_bycx) - NW'(m_bxcy);
        assign nb  = NW'(m_axcy) - NW'(m_aycx);

        always_comb begin
          if (den > 0) begin
            hit[r*16 + e*4 + k] = (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
          end else if (den < 0) begin
            hit[r*16 + e*4 + k] = (na <= 0) && (na >= den) && (nb <= 0) && (nb >= den);
          end else begin
            hit[r*16 + e*4 + k] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (be) begin
      v1        <= pop;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      collided <= (|hit[NUM_PAIRS-1:NUM_BOXES*16])
                  || (obstacles_enabled && (|hit[NUM_BOXES*16-1:0]));
    end
  end

endmodule

>>> hw/rtl/rotated_box_collision_check.sv
// Rotated box collision check.
// Slave stream: one vehicle pose per transfer, tdata = {heading, pos_y, pos_x}.
// Master stream: one result per pose, tdata bit 0 = collided, upper bits zero.
// Config port: cfg_we writes cfg_data into register cfg_index on the clock edge;
//   write only while no pose is in flight.
// Pipeline: 18-stage front (heading fold, 15 CORDIC stages, extent multiply,
//   corner sums), the registered corner queue, then a 3-stage back:
//   differences, products, compare and OR.
// Throughput: one pose per cycle unless stalled; the front CORDIC stages and the back lanes
//   (16 segment pairs per box plus 16 for the arena) are fully pipelined.
// Stalls: a stalled master holds the back end; the 4-entry corner queue keeps
//   the front running until it fills, then s_axis_tready drops.
// Reset (rst, synchronous): all valid bits and queue pointers clear; config
//   returns to its defaults (obstacles on, 1228 x 1228 vehicle, 819 x 2048 boxes
//   at the origin).
module rotated_box_collision_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // collided[0], zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rbcc_pkg::*;

  logic                         obstacles_enabled;
  logic [12:0]                  vehicle_length, vehicle_width;
  logic [12:0]                  box_width, box_height;
  logic [NUM_BOXES-1:0][31:0]   box_corner;

  logic     push, q_full, pop, q_not_empty, collided;
  corners_t f_corners, q_corners;

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacles_enabled <= 1'b1;
      vehicle_length    <= 13'd1228;
      vehicle_width     <= 13'd1228;
      box_width         <= 13'd819;
      box_height        <= 13'd2048;
      box_corner        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBST_EN: obstacles_enabled <= cfg_data[0];
        REG_VEH_LEN: vehicle_length    <= cfg_data[12:0];
        REG_VEH_WID: vehicle_width     <= cfg_data[12:0];
        REG_BOX_WID: box_width         <= cfg_data[12:0];
        REG_BOX_HGT: box_height        <= cfg_data[12:0];
        default: begin
          // box corner registers; indexes past the last box are ignored
          for (int i = 0; i < NUM_BOXES; i++) begin
            if (cfg_index == REG_BOX0 + 3'(i)) box_corner[i] <= cfg_data;
          end
        end
      endcase
    end
  end

  rbcc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .pos_x          (s_axis_tdata[15:0]),
    .pos_y          (s_axis_tdata[31:16]),
    .heading        (s_axis_tdata[47:32]),
    .vehicle_length (vehicle_length),
    .vehicle_width  (vehicle_width),
    .push           (push),
    .corners        (f_corners),
    .q_full         (q_full)
  );

  rbcc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (f_corners),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rdata     (q_corners)
  );

  rbcc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_not_empty       (q_not_empty),
    .pop               (pop),
    .corners           (q_corners),
    .obstacles_enabled (obstacles_enabled),
    .box_width         (box_width),
    .box_height        (box_height),
    .box_corner        (box_corner),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .collided          (collided)
  );

  assign m_axis_tdata = {7'd0, collided};

endmodule

>>> tb/sv/tb_rotated_box_collision_check.sv
module tb_rotated_box_collision_check;
  import rbcc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // pos_x[15:0], pos_y[31:16], heading[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // collided[0], zero fill
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rotated_box_collision_check uut (.*);

  always #1 clk = ~clk;

  // predictor's own copy of the registers
  bit          obst_on;
  bit [12:0]   veh_len, veh_wid, box_w, box_h;
  bit [31:0]   box_xy [NUM_BOXES];

  bit          collide_q [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          n_results = 0;

  typedef struct { longint x, y; } vec_t;

  localparam longint ATAN_T [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1};

  function automatic void pose_trig(input bit [15:0] hd, output longint cs,
                                    output longint sn);
    bit flip;
    bit [15:0] h;
    longint x, y, z, xs, ys;
    h = hd;
    flip = (h >= 16384 && h < 49152);
    if (flip) h = h - 16'd32768;
    z = longint'($signed(h));
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_T[i];
      end else begin
        x += ys; y -= xs; z += ATAN_T[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint half_ext(bit [12:0] e, longint t);
    return (longint'(e) * t + 32768) >>> 16;
  endfunction

  function automatic bit in_span(longint n, longint d);
    if (d > 0) return n >= 0 && n <= d;
    return n <= 0 && n >= d;
  endfunction

  function automatic bit seg_cross(vec_t p1, vec_t p2, vec_t q1, vec_t q2);
    longint ax, ay, bx, by, den, cx, cy, na, nb;
    ax = p2.x - p1.x; ay = p2.y - p1.y;
    bx = q1.x - q2.x; by = q1.y - q2.y;
    den = ay * bx - ax * by;
    if (den == 0) return 0;
    cx = p1.x - q1.x; cy = p1.y - q1.y;
    na = by * cx - bx * cy;
    nb = ax * cy - ay * cx;
    return in_span(na, den) && in_span(nb, den);
  endfunction

  function automatic bit rect_hit(vec_t sd[8], longint x0, longint y0, longint x1,
                                  longint y1);
    vec_t e [8];
    e[0] = '{x1, y0}; e[1] = '{x1, y1};
    e[2] = '{x0, y0}; e[3] = '{x1, y0};
    e[4] = '{x0, y0}; e[5] = '{x0, y1};
    e[6] = '{x0, y1}; e[7] = '{x1, y1};
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 4; k++)
        if (seg_cross(e[2*i], e[2*i+1], sd[2*k], sd[2*k+1])) return 1;
    return 0;
  endfunction

  function automatic bit predict_collision(bit [15:0] px, bit [15:0] py, bit [15:0] hd);
    longint cx, cy, cs, sn, hlc, hls, hwc, hws, bx, by;
    vec_t a, b, c, d;
    vec_t sd [8];
    bit hit;
    cx = longint'($signed(px));
    cy = longint'($signed(py));
    pose_trig(hd, cs, sn);
    hlc = half_ext(veh_len, cs); hls = half_ext(veh_len, sn);
    hwc = half_ext(veh_wid, cs); hws = half_ext(veh_wid, sn);
    a = '{cx + hlc - hws, cy + hls + hwc};
    b = '{cx + hlc + hws, cy + hls - hwc};
    c = '{cx - hlc - hws, cy - hls + hwc};
    d = '{cx - hlc + hws, cy - hls - hwc};
    sd = '{a, b, a, c, c, d, b, d};
    hit = 0;
    if (obst_on)
      for (int i = 0; i < NUM_BOXES && !hit; i++) begin
        bx = longint'($signed(box_xy[i][31:16]));
        by = longint'($signed(box_xy[i][15:0]));
        hit = rect_hit(sd, bx, by - longint'(box_h), bx + longint'(box_w), by);
      end
    if (!hit) hit = rect_hit(sd, 0, 0, ARENA_WIDTH, ARENA_HEIGHT);
    return hit;
  endfunction

  // receiver: stall pattern of its own, check at rising edge
  int stall_mode = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results <= n_results + 1;
      if (collide_q.size() == 0) begin
        $error("unexpected result transfer, collided=%0d", m_axis_tdata[0]);
        fail_cnt++;
      end else begin
        bit want;
        want = collide_q.pop_front();
        if (m_axis_tdata[0] !== want) begin
          $error("collided: expected %0d actual %0d", want, m_axis_tdata[0]);
          fail_cnt++;
        end
        if (m_axis_tdata[7:1] !== 7'd0) begin
          $error("zero fill: expected 0 actual %0h", m_axis_tdata[7:1]);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (cycle_cnt % 7 < 3);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  int burst_left = 0;

  // one pose; bursts of random length, random gaps between
  task automatic send_pose(bit [15:0] px, bit [15:0] py, bit [15:0] hd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hd, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    collide_q.push_back(predict_collision(px, py, hd));
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (collide_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(bit [2:0] idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OBST_EN: obst_on = val[0];
      REG_VEH_LEN: veh_len = val[12:0];
      REG_VEH_WID: veh_wid = val[12:0];
      REG_BOX_WID: box_w = val[12:0];
      REG_BOX_HGT: box_h = val[12:0];
      default: if (idx >= REG_BOX0) box_xy[idx - REG_BOX0] = val;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly near the arena and boxes so crossings happen
  task automatic random_pose();
    bit [15:0] px, py;
    if ($urandom_range(0, 9) < 8) begin
      px = 16'($signed($urandom_range(0, 20000)) - 2000);
      py = 16'($signed($urandom_range(0, 12000)) - 2000);
    end else begin
      px = 16'($urandom);
      py = 16'($urandom);
    end
    send_pose(px, py, 16'($urandom));
  endtask

  task automatic test_defaults_directed();
    bit [15:0] hd [8] = '{16'd0, 16'd16383, 16'd16384, 16'd32768, 16'd49151,
                          16'd49152, 16'd65535, 16'd8192};
    stall_mode = 0;
    foreach (hd[i]) send_pose(16'd0, 16'd0, hd[i]);       // box at origin, arena corner
    send_pose(16'h7fff, 16'h7fff, 16'd0);
    send_pose(16'h8000, 16'h8000, 16'hffff);
    send_pose(16'd8192, 16'd4096, 16'd0);                 // arena center, clear
    send_pose(16'd400, 16'hfc00, 16'd1000);               // crosses the box sides
    send_pose(16'd614, 16'd4096, 16'd0);                  // edge touching wall
    send_pose(16'hffff, 16'h0001, 16'h4000);
    drain();
  endtask

  task automatic test_extremes();
    stall_mode = 1;
    write_reg(REG_VEH_LEN, 32'hffff_ffff);               // unused bits dropped
    write_reg(REG_VEH_WID, 32'd8191);
    write_reg(REG_BOX_WID, 32'd8191);
    write_reg(REG_BOX_HGT, 32'd8191);
    write_reg(REG_BOX0, {16'h7fff, 16'h7fff});
    write_reg(REG_BOX0 + 3'd1, {16'h8000, 16'h8000});
    write_reg(REG_BOX0 + 3'd2, {16'd4000, 16'd5000});
    send_pose(16'h7fff, 16'h7fff, 16'd0);
    send_pose(16'h8000, 16'h8000, 16'd32768);
    send_pose(16'd4000, 16'd4000, 16'd12000);
    drain();
    write_reg(REG_VEH_LEN, 32'd0);                       // degenerate sides
    write_reg(REG_VEH_WID, 32'd0);
    write_reg(REG_BOX_WID, 32'd0);
    write_reg(REG_BOX_HGT, 32'd0);
    send_pose(16'd0, 16'd0, 16'd0);
    send_pose(16'd0, 16'd100, 16'd0);
    drain();
    write_reg(REG_OBST_EN, 32'hffff_fffe);               // bit 0 clear: walls only
    write_reg(REG_BOX0 + 3'd2, 32'hdead_beef);
    write_reg(REG_VEH_LEN, 32'd2000);
    write_reg(REG_VEH_WID, 32'd1000);
    send_pose(16'd400, 16'hfc00, 16'd0);
    send_pose(16'd0, 16'd0, 16'd5000);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      stall_mode = ph % 4;
      write_reg(REG_OBST_EN, $urandom_range(0, 3));
      write_reg(REG_VEH_LEN, (ph == 7) ? 32'd8191 : $urandom_range(0, 4000));
      write_reg(REG_VEH_WID, (ph == 6) ? 32'd0 : $urandom_range(0, 4000));
      write_reg(REG_BOX_WID, $urandom);
      write_reg(REG_BOX_HGT, $urandom);
      for (int b = 0; b < NUM_BOXES; b++)
        write_reg(REG_BOX0 + 3'(b), {16'($urandom_range(0, 16000)),
                                    16'($urandom_range(0, 8000))});
      repeat (210) random_pose();
      drain();
    end
  endtask

  initial begin
    ref_defaults();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_defaults_directed();
    test_extremes();
    test_random_phases();
    if (fail_cnt == 0 && collide_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  function automatic void ref_defaults();
    obst_on = 1;
    veh_len = 1228;
    veh_wid = 1228;
    box_w = 819;
    box_h = 2048;
    foreach (box_xy[i]) box_xy[i] = 0;
  endfunction

endmodule

>>> filelist.f
hw/rtl/rbcc_pkg.sv
hw/rtl/rbcc_front.sv
hw/rtl/rbcc_fifo.sv
hw/rtl/rbcc_back.sv
hw/rtl/rotated_box_collision_check.sv
tb/sv/tb_rotated_box_collision_check.sv
